[rtl/core/bda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

    localparam int unsigned PATTERN_W = 5;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [PATTERN_W-1:0] pattern_t;
    typedef logic [TICKS_W-1:0]   ticks_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN = 2'd0,
        EV_HELD = 2'd1,
        EV_UP   = 2'd2
    } event_kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS   = 1'd1;

    localparam ticks_t DEBOUNCE_RESET = 16'd300;
    localparam ticks_t REPEAT_RESET   = 16'd200;

    // a programmed delay of zero behaves as one tick
    function automatic ticks_t at_least_one(input ticks_t v);
        at_least_one = (v == '0) ? ticks_t'(1) : v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/button_debounce_auto_repeat.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// in       | in_valid / in_ready  | buttons_sample[4:0]
// out      | out_valid/ out_ready | event_kind[1:0], button_pattern[4:0]
// cfg      | cfg_we (no wait)     | cfg_index[0], cfg_data[15:0]
//
// One tick is taken every cycle that in_valid and in_ready are both high; the
// phase, counter and event are worked out in the cycle of the transfer. Events
// are registered in a two-entry output queue, shown on out in order, so ticks
// keep flowing while an event waits; in_ready drops only when the queue is full.
// Reset (rst_n low, async) returns to idle with delays 300 and 200 ticks.

module button_debounce_auto_repeat
    import bda_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PATTERN_W-1:0] buttons_sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KIND_W-1:0]         event_kind,
    output logic [PATTERN_W-1:0]      button_pattern,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]   cfg_data
);

    ticks_t      debounce_reg;
    ticks_t      repeat_reg;
    phase_t      phase_reg, phase_next;
    pattern_t    captured_reg, captured_next;
    ticks_t      count_reg, count_next;
    logic        emit;
    event_kind_t emit_kind;

    event_kind_t q_kind_reg [2];
    pattern_t    q_pat_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg, fill_next;
    logic        accept, push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign accept   = in_valid && in_ready;
    assign push     = accept && emit;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            repeat_reg   <= REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: debounce_reg <= cfg_data;
                CFG_REPEAT_TICKS:   repeat_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        captured_next = captured_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        emit_kind     = EV_DOWN;
        if (accept)
        begin
            case (phase_reg)
                PH_DEBOUNCE, PH_HOLD:
                begin
                    if (count_reg > ticks_t'(1))
                    begin
                        count_next = count_reg - ticks_t'(1);
                    end
                    else if (buttons_sample == captured_reg)
                    begin
                        phase_next = PH_HOLD;
                        count_next = at_least_one(repeat_reg);
                        emit       = 1'b1;
                        emit_kind  = (phase_reg == PH_DEBOUNCE) ? EV_DOWN : EV_HELD;
                    end
                    else
                    begin
                        // a bounce during debounce is dropped silently
                        phase_next = PH_IDLE;
                        count_next = '0;
                        emit       = (phase_reg == PH_HOLD);
                        emit_kind  = EV_UP;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (buttons_sample != '0)
                    begin
                        captured_next = buttons_sample;
                        count_next    = at_least_one(debounce_reg);
                        phase_next    = PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            captured_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            captured_reg <= captured_next;
            count_reg    <= count_next;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_kind_reg[wr_ptr_reg] <= emit_kind;
            q_pat_reg[wr_ptr_reg]  <= captured_reg;
        end
    end

    assign out_valid      = (fill_reg != 2'd0);
    assign event_kind     = q_kind_reg[rd_ptr_reg];
    assign button_pattern = q_pat_reg[rd_ptr_reg];

endmodule

`default_nettype wire
